### rtl/brv_pkg.sv
// Shared types and constants for the baseline recalibration frame vote block.
`default_nettype none

package brv_pkg;

    localparam logic [3:0] SKIP_FRAMES   = 4'd5;
    localparam logic [3:0] WINDOW_FRAMES = 4'd15;
    localparam logic [3:0] VOTE_LIMIT    = 4'd2;
    localparam logic [3:0] VOTE_MAX      = 4'd15;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_ACK   = 1'b1;

    localparam logic [1:0] REG_SIGNAL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RAW_CENTER       = 2'd1;
    localparam logic [1:0] REG_RAW_SPAN         = 2'd2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic [3:0]  fc;
        logic [3:0]  votes;
        logic        latch;
        logic [15:0] mn;
        logic [15:0] mx;
    } t_state;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        pixel;
        logic               last;
        logic signed [15:0] max_sig;
        logic signed [15:0] min_sig;
        logic               reset_win;
        logic               auto_cal;
    } t_item;

    typedef struct packed {
        logic [14:0] thr;
        logic [15:0] center;
        logic [15:0] span;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/brv_judge.sv
// Next-state and result logic for one request: extremes update and frame rule.
`default_nettype none

module brv_judge
    import brv_pkg::*;
(
    input  t_state i_state,
    input  t_item  i_item,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output logic   o_new_req
);

    logic [15:0]        mn_u;
    logic [15:0]        mx_u;
    logic [14:0]        half;
    logic [16:0]        upper;
    logic [15:0]        lower;
    logic signed [16:0] thr_s;
    logic signed [16:0] max_s;
    logic signed [16:0] min_s;
    logic               sig_excl;
    logic               abnormal;
    logic [3:0]         fc0;
    logic [3:0]         votes0;
    logic               latch0;

    assign mn_u   = (i_item.pixel < i_state.mn) ? i_item.pixel : i_state.mn;
    assign mx_u   = (i_item.pixel > i_state.mx) ? i_item.pixel : i_state.mx;
    assign half   = i_cfg.span[15:1];
    assign upper  = {1'b0, i_cfg.center} + {2'b00, half};
    assign lower  = (i_cfg.center > {1'b0, half}) ? (i_cfg.center - {1'b0, half}) : 16'd0;
    assign thr_s  = $signed({2'b00, i_cfg.thr});
    assign max_s  = $signed({i_item.max_sig[15], i_item.max_sig});
    assign min_s  = $signed({i_item.min_sig[15], i_item.min_sig});
    assign sig_excl = (max_s >= thr_s) || (min_s <= -thr_s);
    // extremes include this pixel, so max >= min
    assign abnormal = ((mx_u - mn_u) > i_cfg.span) || ({1'b0, mx_u} > upper) || (mn_u < lower);

    assign fc0    = i_item.reset_win ? 4'd0 : i_state.fc;
    assign votes0 = i_item.reset_win ? 4'd0 : i_state.votes;
    assign latch0 = i_item.reset_win ? 1'b0 : i_state.latch;

    always_comb begin
        o_state   = i_state;
        o_new_req = 1'b0;
        if (i_item.opcode == OP_ACK) begin
            o_state.latch = 1'b0;
            o_state.fc    = 4'd0;
            o_state.votes = 4'd0;
        end else if (!i_item.last) begin
            o_state.mn = mn_u;
            o_state.mx = mx_u;
        end else begin
            o_state.mn    = 16'hFFFF;
            o_state.mx    = 16'd0;
            o_state.fc    = fc0;
            o_state.votes = votes0;
            o_state.latch = latch0;
            if (fc0 < SKIP_FRAMES) begin
                o_state.fc = fc0 + 4'd1;
            end else if (fc0 < WINDOW_FRAMES) begin
                o_state.fc = fc0 + 4'd1;
                if (!sig_excl && abnormal && (votes0 < VOTE_MAX)) begin
                    o_state.votes = votes0 + 4'd1;
                end
            end else begin
                if ((votes0 > VOTE_LIMIT) && !i_item.auto_cal && !latch0) begin
                    o_state.latch = 1'b1;
                    o_new_req     = 1'b1;
                end
                o_state.votes = 4'd0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/baseline_recal_frame_vote.sv
// Top level of the baseline recalibration frame vote block.
// Takes one request per clock while not stalled: pixels (tuser = 0) and acknowledges (tuser = 1).
// Each request is held in an input register, where the counter, vote,
// latch and min/max state is updated as the request advances, and a last
// pixel loads a result into the output register, which drives
// m_axis_tvalid; a result passes the input register and then the output
// register. The state update loop sets the rate of one request per cycle;
// the input side keeps taking requests while a result waits downstream,
// and stalls only while a last pixel in the input register waits for the
// output register to be taken.
`default_nettype none

module baseline_recal_frame_vote
    import brv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_value[15:0], frame_max_signal[31:16], frame_min_signal[47:32],
    // reset_window[48], auto_cal_active[49], zero[55:50]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // opcode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // req_raised[0], request_pending[1], zero[7:2]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_item;
    t_item  in_item;
    logic   r_in_vld;
    logic   r_out_vld;
    logic   r_out_new;
    logic   r_out_pend;
    logic   new_req;
    logic   gives_result;
    logic   out_free;
    logic   advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIGNAL_THRESHOLD: r_cfg.thr    <= i_cfg_data[14:0];
                REG_RAW_CENTER:       r_cfg.center <= i_cfg_data;
                REG_RAW_SPAN:         r_cfg.span   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.opcode    = s_axis_tuser;
    assign in_item.pixel     = s_axis_tdata[15:0];
    assign in_item.last      = s_axis_tlast;
    assign in_item.max_sig   = s_axis_tdata[31:16];
    assign in_item.min_sig   = s_axis_tdata[47:32];
    assign in_item.reset_win = s_axis_tdata[48];
    assign in_item.auto_cal  = s_axis_tdata[49];

    assign gives_result  = (r_item.opcode == OP_PIXEL) && r_item.last;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign advance       = r_in_vld && (!gives_result || out_free);
    assign s_axis_tready = !r_in_vld || advance;

    brv_judge u_judge (
        .i_state   (r_state),
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .o_state   (n_state),
        .o_new_req (new_req)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.fc    <= 4'd0;
            r_state.votes <= 4'd0;
            r_state.latch <= 1'b0;
            r_state.mn    <= 16'hFFFF;
            r_state.mx    <= 16'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= advance && gives_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && gives_result) begin
            r_out_new  <= new_req;
            r_out_pend <= n_state.latch;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_pend, r_out_new};

    a_new_implies_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out_new || r_out_pend))
        else $error("new request reported without pending latch");

    a_votes_after_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.votes != 4'd0) |-> (r_state.fc > SKIP_FRAMES))
        else $error("votes present during skip frames");

    a_latch_rise_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state.latch) |-> (r_out_vld && r_out_new))
        else $error("latch raised without a reported request");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire
